// ----- rtl/core/target_yaw_aim_controller_unit_macros.svh -----
// Assertion macros for the checker file of the yaw aim controller.
`ifndef TARGET_YAW_AIM_CONTROLLER_UNIT_MACROS_SVH
`define TARGET_YAW_AIM_CONTROLLER_UNIT_MACROS_SVH
// Clocked assertion that is off during reset.
`define TYA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that also holds during reset.
`define TYA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- rtl/core/tya_pkg.sv -----
// Shared types, constants and the arctangent table of the yaw aim controller.
`timescale 1ns / 1ps
`default_nettype none
package tya_pkg;

  // Result status codes
  localparam logic [2:0] ST_WAIT    = 3'd0;
  localparam logic [2:0] ST_CORRECT = 3'd1;
  localparam logic [2:0] ST_CREEP   = 3'd2;
  localparam logic [2:0] ST_SETTLE  = 3'd3;
  localparam logic [2:0] ST_FIRE    = 3'd4;
  localparam logic [2:0] ST_TIMEOUT = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] CFG_TARGET_TAG  = 3'd0;
  localparam logic [2:0] CFG_PROP_GAIN   = 3'd1;
  localparam logic [2:0] CFG_INTEG_GAIN  = 3'd2;
  localparam logic [2:0] CFG_INTEG_LIMIT = 3'd3;
  localparam logic [2:0] CFG_FIRE_TOL    = 3'd4;
  localparam logic [2:0] CFG_SETTLE_TOL  = 3'd5;
  localparam logic [2:0] CFG_MIN_RATE    = 3'd6;
  localparam logic [2:0] CFG_TIMEOUT     = 3'd7;

  // Timing and range constants
  localparam int STALE_MS   = 1000;
  localparam int CONFIRM_MS = 500;
  localparam int CREEP_MS   = 3000;
  localparam int WINDOW_MS  = 500;
  localparam int Z_MIN_Q16  = 3276;
  localparam int RATE_SAT   = 22938;
  // ceil(2^36 / 1000): exact quotient by 1000 for operands below 2^26
  localparam int DIV_SHIFT  = 36;
  localparam logic [26:0] RECIP_1000 = 27'd68719477;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       load_in;
    logic       store_det;
    logic       cord_init;
    logic       cord_step;
    logic       set_near;
    logic       set_conf;
    logic       clr_integ;
    logic       pi_p;
    logic       pi_q;
    logic       pi_acc;
    logic       pi_mul;
    logic       res_load;
    logic       res_pi;
    logic [2:0] res_status;
  } tya_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic mode;
    logic tag_hit;
    logic timeout;
    logic stale;
    logic z_low;
    logic cord_last;
    logic near_hit;
    logic settle_hit;
    logic conf_over;
    logic creep_over;
  } tya_sts_t;

  // atan(2^-i) in Q30
  function automatic logic [30:0] atan_q30(input logic [4:0] i);
    logic [30:0] v;
    case (i)
      5'd0:  v = 31'd843314857;
      5'd1:  v = 31'd497837829;
      5'd2:  v = 31'd263043837;
      5'd3:  v = 31'd133525159;
      5'd4:  v = 31'd67021687;
      5'd5:  v = 31'd33543516;
      5'd6:  v = 31'd16775851;
      5'd7:  v = 31'd8388437;
      5'd8:  v = 31'd4194283;
      5'd9:  v = 31'd2097149;
      5'd10: v = 31'd1048576;
      5'd11: v = 31'd524288;
      5'd12: v = 31'd262144;
      5'd13: v = 31'd131072;
      5'd14: v = 31'd65536;
      5'd15: v = 31'd32768;
      5'd16: v = 31'd16384;
      5'd17: v = 31'd8192;
      5'd18: v = 31'd4096;
      5'd19: v = 31'd2048;
      5'd20: v = 31'd1024;
      5'd21: v = 31'd512;
      5'd22: v = 31'd256;
      5'd23: v = 31'd128;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/target_yaw_aim_controller_unit.sv -----
// Top level of the target yaw aim controller.
//
// Input stream: detections (in_tuser = 1) store the target's x, z and time
// stamp when the tag matches the configured target and aiming has not
// finished; control ticks (in_tuser = 0) run the aim step and give one result
// on the output stream (none once finished). One item is worked at a time:
// in_tready is high only while the block is idle.
// Sequence: a detection is loaded and evaluated. A tick that times out or
// waits goes from evaluation to the emit state; a tick that reaches the angle
// unit runs the one-step-per-cycle CORDIC loop for CORDIC_STEPS steps and the
// judge state, then emits settle/fire or goes through the five PI steps.
// The output register frees the core: if the receiver stalls, the block still
// takes the next item and holds a new result in its emit state until the
// register is taken.
// Reset (synchronous, rst_n low) restores the register defaults, clears all
// aim state and empties the output register.
`timescale 1ns / 1ps
`default_nettype none
module target_yaw_aim_controller_unit #(
  parameter int CORDIC_STEPS = 16,
  parameter int FRAC_BITS    = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [9:0] tag_id, [33:10] pos_x, [57:34] pos_z, [89:58] time_ms, rest zero
  input  wire logic [95:0] in_tdata,
  // [0] mode
  input  wire logic        in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [15:0] rate_cmd, [18:16] status, rest zero
  output logic [23:0]      out_tdata
);
  import tya_pkg::*;

  tya_cmd_t    cmd;
  tya_sts_t    sts;
  logic        push, out_free;
  logic [15:0] res_rate;
  logic [2:0]  res_status;
  logic        out_valid_r;
  logic [23:0] out_data_r;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  tya_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .out_free (out_free),
    .push     (push),
    .sts      (sts),
    .cmd      (cmd)
  );

  tya_datapath #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_mode    (in_tuser),
    .in_tag_id  (in_tdata[9:0]),
    .in_pos_x   (in_tdata[33:10]),
    .in_pos_z   (in_tdata[57:34]),
    .in_time_ms (in_tdata[89:58]),
    .cmd        (cmd),
    .sts        (sts),
    .res_rate   (res_rate),
    .res_status (res_status)
  );

  // Output register: load on push, drop after transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) out_data_r <= {5'd0, res_status, res_rate};
  end

endmodule
`default_nettype wire

// ----- rtl/core/tya_datapath.sv -----
// Datapath: configuration, held target, CORDIC angle unit and PI arithmetic.
`timescale 1ns / 1ps
`default_nettype none
module tya_datapath #(
  parameter int CORDIC_STEPS = 16,
  parameter int FRAC_BITS    = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_addr,
  input  wire logic [15:0]       cfg_wdata,
  input  wire logic              in_mode,
  input  wire logic [9:0]        in_tag_id,
  input  wire logic [23:0]       in_pos_x,
  input  wire logic [23:0]       in_pos_z,
  input  wire logic [31:0]       in_time_ms,
  input  wire tya_pkg::tya_cmd_t cmd,
  output tya_pkg::tya_sts_t      sts,
  output logic [15:0]            res_rate,
  output logic [2:0]             res_status
);
  import tya_pkg::*;

  localparam int CW  = 36;
  localparam int AW  = FRAC_BITS + 3;
  localparam int SH  = 30 - FRAC_BITS;
  localparam int DN  = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
  localparam int UP  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int XW  = AW + UP + 1;
  localparam int IW  = $clog2(CORDIC_STEPS);
  localparam int EW  = 20;
  localparam logic signed [XW-1:0] RND = XW'((DN == 0) ? 0 : (1 << (DN - 1)));

  // Configuration registers
  logic signed [10:0] tag_r;
  logic [15:0] pg_r, ig_r, lim_r, fire_r, settle_r, minr_r, tmo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r    <= -11'sd1;
      pg_r     <= 16'd8192;
      ig_r     <= 16'd1229;
      lim_r    <= 16'd9830;
      fire_r   <= 16'd1311;
      settle_r <= 16'd524;
      minr_r   <= 16'd3277;
      tmo_r    <= 16'd8000;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_TARGET_TAG:  tag_r    <= cfg_wdata[10:0];
        CFG_PROP_GAIN:   pg_r     <= cfg_wdata;
        CFG_INTEG_GAIN:  ig_r     <= cfg_wdata;
        CFG_INTEG_LIMIT: lim_r    <= cfg_wdata;
        CFG_FIRE_TOL:    fire_r   <= cfg_wdata;
        CFG_SETTLE_TOL:  settle_r <= cfg_wdata;
        CFG_MIN_RATE:    minr_r   <= cfg_wdata;
        CFG_TIMEOUT:     tmo_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Latched input item
  logic        mode_r;
  logic [9:0]  tid_r;
  logic [23:0] px_r, pz_r;
  logic [31:0] now_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r <= in_mode;
      tid_r  <= in_tag_id;
      px_r   <= in_pos_x;
      pz_r   <= in_pos_z;
      now_r  <= in_time_ms;
    end
  end

  // Held target and time stamps
  logic signed [23:0] hx_r, hz_r;
  logic [31:0] seen_r, cb_r, nb_r, prev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hx_r   <= '0;
      hz_r   <= '0;
      seen_r <= '0;
      cb_r   <= '0;
      nb_r   <= '0;
      prev_r <= '0;
    end else begin
      if (cmd.store_det) begin
        hx_r   <= px_r;
        hz_r   <= pz_r;
        seen_r <= now_r;
      end
      if (cmd.set_near) nb_r <= now_r;
      if (cmd.set_conf) cb_r <= now_r;
      if (cmd.pi_p) prev_r <= now_r;
    end
  end

  // CORDIC vectoring, one step per cycle
  logic signed [CW-1:0] cx_r, cy_r, sx, sy;
  logic signed [AW-1:0] ang_r, step;
  logic [IW-1:0] cnt_r;

  assign sx   = cx_r >>> cnt_r;
  assign sy   = cy_r >>> cnt_r;
  assign step = AW'((atan_q30(5'(cnt_r)) + (31'd1 << (SH - 1))) >> SH);

  always_ff @(posedge clk) begin
    if (cmd.cord_init) begin
      cx_r  <= {{(CW-32){hz_r[23]}}, hz_r, 8'd0};
      cy_r  <= {{(CW-32){hx_r[23]}}, hx_r, 8'd0};
      ang_r <= '0;
      cnt_r <= '0;
    end else if (cmd.cord_step) begin
      if (!cy_r[CW-1]) begin
        cx_r  <= cx_r + sy;
        cy_r  <= cy_r - sx;
        ang_r <= ang_r + step;
      end else begin
        cx_r  <= cx_r - sy;
        cy_r  <= cy_r + sx;
        ang_r <= ang_r - step;
      end
      cnt_r <= cnt_r + IW'(1);
    end
  end

  // Angle to Q16 radians and its magnitude
  logic signed [XW-1:0] ang_x, ang_q;
  logic signed [EW-1:0] err;
  logic [EW-1:0] aerr;

  assign ang_x = XW'(ang_r);
  assign ang_q = ((ang_x + RND) >>> DN) <<< UP;
  assign err   = EW'(ang_q);
  assign aerr  = err[EW-1] ? EW'(-err) : EW'(err);

  // PI: time step and product err*dt
  logic signed [31:0] dt, el_seen, el_cb, el_nb;
  logic win_r;
  logic signed [29:0] p_r;

  assign dt      = $signed(now_r - prev_r);
  assign el_seen = $signed(now_r - seen_r);
  assign el_cb   = $signed(now_r - cb_r);
  assign el_nb   = $signed(now_r - nb_r);

  always_ff @(posedge clk) begin
    if (cmd.pi_p) begin
      win_r <= (dt > 32'sd0) && (dt < 32'(WINDOW_MS));
      p_r   <= err * $signed(dt[9:0]);
    end
  end

  // PI: rounded quotient by 1000 through the reciprocal
  logic [29:0] pmag;
  logic        pneg_r;
  logic [53:0] prod_r;

  assign pmag = p_r[29] ? 30'(-p_r) : 30'(p_r);

  always_ff @(posedge clk) begin
    if (cmd.pi_q) begin
      pneg_r <= p_r[29];
      prod_r <= (27'(pmag) + 27'd500) * RECIP_1000;
    end
  end

  // PI: integrate and clamp
  logic signed [17:0] integ_r;
  logic signed [19:0] isum, ilim;
  logic [17:0] q;

  assign q    = prod_r[DIV_SHIFT +: 18];
  assign ilim = {4'd0, lim_r};
  assign isum = pneg_r ? 20'(integ_r) - $signed({2'b0, q}) : 20'(integ_r) + $signed({2'b0, q});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
    end else if (cmd.clr_integ) begin
      integ_r <= '0;
    end else if (cmd.pi_acc && win_r) begin
      if (isum > ilim) integ_r <= 18'(ilim);
      else if (isum < -ilim) integ_r <= 18'(-ilim);
      else integ_r <= 18'(isum);
    end
  end

  // PI: gain products
  logic signed [36:0] mp_r, mi_r;

  always_ff @(posedge clk) begin
    if (cmd.pi_mul) begin
      mp_r <= $signed({1'b0, pg_r}) * err;
      mi_r <= $signed({1'b0, ig_r}) * 20'(integ_r);
    end
  end

  // Command: round, floor, negate, saturate
  logic signed [37:0] tot;
  logic signed [25:0] cm, fl;
  logic signed [26:0] ng;
  logic [25:0] cabs;
  logic signed [15:0] sat;

  always_comb begin
    tot  = 38'(mp_r) + 38'(mi_r) + 38'sd2048;
    cm   = 26'(tot >>> 12);
    cabs = cm[25] ? 26'(-cm) : 26'(cm);
    if (cabs < 26'(minr_r)) fl = cm[25] ? -$signed({10'd0, minr_r}) : $signed({10'd0, minr_r});
    else fl = cm;
    ng = -27'(fl);
    if (ng > 27'(RATE_SAT)) sat = 16'(RATE_SAT);
    else if (ng < -27'(RATE_SAT)) sat = -16'(RATE_SAT);
    else sat = 16'(ng);
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_rate   <= cmd.res_pi ? sat : 16'd0;
      res_status <= cmd.res_status;
    end
  end

  // Status toward the controller
  always_comb begin
    sts.mode       = mode_r;
    sts.tag_hit    = (tag_r == $signed({1'b0, tid_r}));
    sts.timeout    = now_r > {16'd0, tmo_r};
    sts.stale      = el_seen > 32'(STALE_MS);
    sts.z_low      = hz_r <= 24'(Z_MIN_Q16);
    sts.cord_last  = cnt_r == IW'(CORDIC_STEPS - 1);
    sts.near_hit   = aerr < EW'(fire_r);
    sts.settle_hit = aerr < EW'(settle_r);
    sts.conf_over  = el_cb >= 32'(CONFIRM_MS);
    sts.creep_over = el_nb > 32'(CREEP_MS);
  end

endmodule
`default_nettype wire

// ----- rtl/core/tya_ctrl.sv -----
// Controller state machine that sequences one item through the datapath.
`timescale 1ns / 1ps
`default_nettype none
module tya_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              out_free,
  output logic                   push,
  input  wire tya_pkg::tya_sts_t sts,
  output tya_pkg::tya_cmd_t      cmd
);
  import tya_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_EVAL  = 10'b0000000010,
    S_CORD  = 10'b0000000100,
    S_JUDGE = 10'b0000001000,
    S_PIP   = 10'b0000010000,
    S_PIQ   = 10'b0000100000,
    S_PIA   = 10'b0001000000,
    S_PIM   = 10'b0010000000,
    S_PIC   = 10'b0100000000,
    S_EMIT  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic fin_r, fin_nxt, seen_r, seen_nxt, conf_r, conf_nxt;
  logic near_r, near_nxt, creep_r, creep_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    fin_nxt   = fin_r;
    seen_nxt  = seen_r;
    conf_nxt  = conf_r;
    near_nxt  = near_r;
    creep_nxt = creep_r;
    cmd       = '0;
    push      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_IDLE;
        if (sts.mode) begin
          if (!fin_r && sts.tag_hit) begin
            cmd.store_det = 1'b1;
            seen_nxt      = 1'b1;
          end
        end else if (!fin_r) begin
          if (sts.timeout) begin
            fin_nxt        = 1'b1;
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_TIMEOUT;
            state_nxt      = S_EMIT;
          end else if (!seen_r || sts.stale || sts.z_low) begin
            conf_nxt       = 1'b0;
            near_nxt       = 1'b0;
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_WAIT;
            state_nxt      = S_EMIT;
          end else begin
            cmd.cord_init = 1'b1;
            state_nxt     = S_CORD;
          end
        end
      end
      S_CORD: begin
        cmd.cord_step = 1'b1;
        if (sts.cord_last) state_nxt = S_JUDGE;
      end
      S_JUDGE: begin
        if (sts.near_hit) begin
          if (!near_r) begin
            near_nxt     = 1'b1;
            cmd.set_near = 1'b1;
          end
          if (sts.settle_hit) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_SETTLE;
            state_nxt      = S_EMIT;
            if (!conf_r) begin
              conf_nxt      = 1'b1;
              cmd.set_conf  = 1'b1;
              cmd.clr_integ = 1'b1;
            end else if (sts.conf_over) begin
              fin_nxt        = 1'b1;
              cmd.res_status = ST_FIRE;
            end
          end else begin
            conf_nxt  = 1'b0;
            creep_nxt = 1'b1;
            state_nxt = S_PIP;
          end
        end else begin
          near_nxt  = 1'b0;
          conf_nxt  = 1'b0;
          creep_nxt = 1'b0;
          state_nxt = S_PIP;
        end
      end
      S_PIP: begin
        cmd.pi_p  = 1'b1;
        state_nxt = S_PIQ;
      end
      S_PIQ: begin
        cmd.pi_q  = 1'b1;
        state_nxt = S_PIA;
      end
      S_PIA: begin
        cmd.pi_acc = 1'b1;
        state_nxt  = S_PIM;
      end
      S_PIM: begin
        cmd.pi_mul = 1'b1;
        state_nxt  = S_PIC;
      end
      S_PIC: begin
        cmd.res_load = 1'b1;
        state_nxt    = S_EMIT;
        if (creep_r && sts.creep_over) begin
          fin_nxt        = 1'b1;
          cmd.res_status = ST_FIRE;
        end else begin
          cmd.res_pi     = 1'b1;
          cmd.res_status = creep_r ? ST_CREEP : ST_CORRECT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          push      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fin_r   <= 1'b0;
      seen_r  <= 1'b0;
      conf_r  <= 1'b0;
      near_r  <= 1'b0;
      creep_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
      seen_r  <= seen_nxt;
      conf_r  <= conf_nxt;
      near_r  <= near_nxt;
      creep_r <= creep_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/tya_checker.sv -----
// Port checker for the yaw aim controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "target_yaw_aim_controller_unit_macros.svh"
module tya_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata
);
  import tya_pkg::*;

  `TYA_ASSERT(a_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")
  `TYA_ASSERT(a_zero_rate, out_tvalid && out_tdata[18:16] != ST_CORRECT && out_tdata[18:16] != ST_CREEP |-> out_tdata[15:0] == 16'd0, "nonzero rate for a non-PI status")
  `TYA_ASSERT(a_status, out_tvalid |-> out_tdata[18:16] <= ST_TIMEOUT && out_tdata[23:19] == 5'd0, "bad status or padding")
  `TYA_ASSERT_ALWAYS(a_reset, !rst_n |=> !out_tvalid && in_tready, "reset did not clear the block")

endmodule

bind target_yaw_aim_controller_unit tya_checker u_tya_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

// ----- dv/target_yaw_aim_controller_unit_tb.sv -----
// Self-checking testbench for the target yaw aim controller: directed tables, random phases, then an ending.
`timescale 1ns / 1ps
module target_yaw_aim_controller_unit_tb;
  import tya_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int PHASE_ITEMS = 280;
  localparam int MODE_TICK = 0;
  localparam int MODE_DET = 1;

  // Arctangent of 2^-i in Q30
  localparam longint ATAN_Q30 [16] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768};

  typedef struct {
    int     tag;
    longint pgain, igain, ilimit, ftol, stol, minr, tmo;
  } aim_cfg_t;

  typedef struct {
    bit        finished, seen, confirming, near;
    longint    hx, hz, integ;
    bit [31:0] seen_t, conf_t, near_t, prev_t;
  } aim_state_t;

  typedef struct {
    logic [15:0] rate;
    logic [2:0]  status;
  } aim_result_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [2:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        in_tuser = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [23:0] out_tdata;

  aim_cfg_t    cfg;
  aim_state_t  aim;
  aim_result_t pending_results[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          calm_send = 0;
  bit          calm_recv = 0;
  int          cur_t = 0;

  target_yaw_aim_controller_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #10 clk = ~clk;

  // Signed wrapping difference of two millisecond stamps
  function automatic longint ms_since(bit [31:0] now, bit [31:0] then);
    bit [31:0] d;
    d = now - then;
    return longint'($signed(d));
  endfunction

  // Yaw error atan2(x, z) in Q16 radians by CORDIC vectoring
  function automatic longint yaw_error(longint x, longint z);
    longint xv, yv, ang, stp, nx, ny;
    xv = z * 256;
    yv = x * 256;
    ang = 0;
    for (int i = 0; i < 16; i++) begin
      stp = (ATAN_Q30[i] + (64'sd1 << 13)) >>> 14;
      if (yv >= 0) begin
        nx = xv + (yv >>> i);
        ny = yv - (xv >>> i);
        ang += stp;
      end else begin
        nx = xv - (yv >>> i);
        ny = yv + (xv >>> i);
        ang -= stp;
      end
      xv = nx;
      yv = ny;
    end
    return ang;
  endfunction

  // PI turn command; integrates only inside the time window
  function automatic longint pi_turn(inout aim_state_t s, input aim_cfg_t c,
                                     input bit [31:0] now, input longint err);
    longint dt, p, mag, q;
    dt = ms_since(now, s.prev_t);
    s.prev_t = now;
    if (dt > 0 && dt < WINDOW_MS) begin
      p = err * dt;
      mag = (p < 0) ? -p : p;
      q = (mag + 500) / 1000;
      s.integ += (p < 0) ? -q : q;
      if (s.integ > c.ilimit) s.integ = c.ilimit;
      if (s.integ < -c.ilimit) s.integ = -c.ilimit;
    end
    return (c.pgain * err + c.igain * s.integ + 2048) >>> 12;
  endfunction

  function automatic longint rate_floor(longint cmd, longint minr);
    longint a;
    a = (cmd < 0) ? -cmd : cmd;
    if (a < minr) return (cmd >= 0) ? minr : -minr;
    return cmd;
  endfunction

  function automatic aim_result_t make_result(longint rate, logic [2:0] st);
    aim_result_t r;
    if (rate > RATE_SAT) rate = RATE_SAT;
    if (rate < -RATE_SAT) rate = -RATE_SAT;
    r.rate = rate[15:0];
    r.status = st;
    return r;
  endfunction

  // Advance the aim state by one item; return 1 when a result is produced
  function automatic bit aim_step(inout aim_state_t s, input aim_cfg_t c, input bit mode,
                                  input bit [9:0] tag, input bit [23:0] x, input bit [23:0] z,
                                  input bit [31:0] now, output aim_result_t r);
    longint err, aerr, cmd;
    r = make_result(0, ST_WAIT);
    if (mode) begin
      if (!s.finished && c.tag == int'(tag)) begin
        s.hx = longint'($signed(x));
        s.hz = longint'($signed(z));
        s.seen_t = now;
        s.seen = 1;
      end
      return 0;
    end
    if (s.finished) return 0;
    if (longint'(now) > c.tmo) begin
      s.finished = 1;
      r = make_result(0, ST_TIMEOUT);
      return 1;
    end
    if (!s.seen || ms_since(now, s.seen_t) > STALE_MS || s.hz <= Z_MIN_Q16) begin
      s.confirming = 0;
      s.near = 0;
      return 1;
    end
    err = yaw_error(s.hx, s.hz);
    aerr = (err < 0) ? -err : err;
    if (aerr < c.ftol) begin
      if (!s.near) begin
        s.near = 1;
        s.near_t = now;
      end
      if (aerr < c.stol) begin
        if (!s.confirming) begin
          s.confirming = 1;
          s.conf_t = now;
          s.integ = 0;
        end else if (ms_since(now, s.conf_t) >= CONFIRM_MS) begin
          s.finished = 1;
          r = make_result(0, ST_FIRE);
          return 1;
        end
        r = make_result(0, ST_SETTLE);
        return 1;
      end
      s.confirming = 0;
      cmd = pi_turn(s, c, now, err);
      if (ms_since(now, s.near_t) > CREEP_MS) begin
        s.finished = 1;
        r = make_result(0, ST_FIRE);
        return 1;
      end
      r = make_result(-rate_floor(cmd, c.minr), ST_CREEP);
      return 1;
    end
    s.near = 0;
    s.confirming = 0;
    cmd = rate_floor(pi_turn(s, c, now, err), c.minr);
    r = make_result(-cmd, ST_CORRECT);
    return 1;
  endfunction

  // Write one register; caller stands at a rising edge
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_TARGET_TAG:  cfg.tag = int'($signed(val[10:0]));
      CFG_PROP_GAIN:   cfg.pgain = val;
      CFG_INTEG_GAIN:  cfg.igain = val;
      CFG_INTEG_LIMIT: cfg.ilimit = val;
      CFG_FIRE_TOL:    cfg.ftol = val;
      CFG_SETTLE_TOL:  cfg.stol = val;
      CFG_MIN_RATE:    cfg.minr = val;
      default:         cfg.tmo = val;
    endcase
    @(posedge clk);
  endtask

  task automatic write_all(logic [15:0] tag, logic [15:0] pg, logic [15:0] ig,
                           logic [15:0] lim, logic [15:0] ft, logic [15:0] stl,
                           logic [15:0] mr, logic [15:0] tmo);
    write_reg(CFG_TARGET_TAG, tag);
    write_reg(CFG_PROP_GAIN, pg);
    write_reg(CFG_INTEG_GAIN, ig);
    write_reg(CFG_INTEG_LIMIT, lim);
    write_reg(CFG_FIRE_TOL, ft);
    write_reg(CFG_SETTLE_TOL, stl);
    write_reg(CFG_MIN_RATE, mr);
    write_reg(CFG_TIMEOUT, tmo);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // Hold the sender until every expected result has arrived, then let the core settle
  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Send one item; a typed expectation overrides the predicted one
  task automatic send(bit mode, bit [9:0] tag, bit [23:0] x, bit [23:0] z, bit [31:0] t,
                      bit typed = 0, logic [15:0] erate = '0, logic [2:0] estat = ST_WAIT);
    int gap;
    aim_result_t r;
    gap = calm_send ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= mode;
    in_tdata <= {6'b0, t, z, x, tag};
    do @(posedge clk); while (!in_tready);
    if (aim_step(aim, cfg, mode, tag, x, z, t, r)) begin
      if (typed) begin
        r.rate = erate;
        r.status = estat;
      end
      pending_results.push_back(r);
    end
  endtask

  task automatic end_send();
    in_tvalid <= 0;
    @(posedge clk);
  endtask

  // Random item within a phase; ticks that would end aiming are steered away
  task automatic random_item();
    bit          mode;
    bit [9:0]    tag;
    bit [23:0]   x, z;
    bit [31:0]   t;
    int          r, zi, k;
    aim_state_t  trial;
    aim_result_t res;
    r = $urandom_range(0, 99);
    mode = (r < 35);
    tag = (r < 30 && cfg.tag >= 0) ? cfg.tag[9:0] : 10'($urandom);
    r = $urandom_range(0, 99);
    if (r < 75) zi = $urandom_range(3277, 1 << 20);
    else if (r < 85) zi = $urandom_range(0, 6552) - 3276;
    else zi = int'($signed(24'($urandom)));
    z = zi[23:0];
    if ($urandom_range(0, 1)) begin
      k = $urandom_range(0, 160) - 80;
      x = 24'((longint'(zi) * k) / 4096);
    end else begin
      x = 24'($urandom);
    end
    r = $urandom_range(0, 99);
    if (mode) begin
      if (r < 85) t = (cur_t > 50) ? cur_t - $urandom_range(0, 50) : cur_t;
      else t = $urandom;
      send(mode, tag, x, z, t);
      return;
    end
    if (r < 5) cur_t += $urandom_range(0, 1500);
    else if (r < 8) cur_t = (cur_t > 2000) ? cur_t - $urandom_range(0, 2000) : 0;
    else cur_t += $urandom_range(0, 150);
    if (longint'(cur_t) > cfg.tmo) cur_t = $urandom_range(0, int'(cfg.tmo));
    t = cur_t;
    for (int tries = 0; tries < 8; tries++) begin
      trial = aim;
      if (!aim_step(trial, cfg, 0, tag, x, z, t, res) ||
          (res.status != ST_FIRE && res.status != ST_TIMEOUT)) break;
      cur_t = $urandom_range(0, int'(cfg.tmo));
      t = cur_t;
    end
    trial = aim;
    if (aim_step(trial, cfg, 0, tag, x, z, t, res) &&
        (res.status == ST_FIRE || res.status == ST_TIMEOUT)) begin
      // Fall back to a detection that cannot match
      send(1, (cfg.tag >= 0) ? cfg.tag[9:0] ^ 10'd1 : tag, x, z, t);
    end else begin
      send(0, tag, x, z, t);
    end
  endtask

  typedef struct {
    bit          mode;
    bit [9:0]    tag;
    bit [23:0]   x, z;
    bit [31:0]   t;
    bit          typed;
    logic [15:0] rate;
    logic [2:0]  status;
  } stim_row_t;

  // Directed rows at reset settings, then with tag 1023 selected
  stim_row_t reset_rows[3] = '{
    '{MODE_TICK, 0, 0, 0, 0, 1, 0, ST_WAIT},
    '{MODE_DET, 10'd1023, 24'h7FFFFF, 24'h7FFFFF, 0, 0, 0, ST_WAIT},
    '{MODE_TICK, 0, 0, 0, 8000, 1, 0, ST_WAIT}};

  stim_row_t aim_rows[16] = '{
    '{MODE_DET, 10'd1023, 24'd0, 24'd65536, 100, 0, 0, ST_WAIT},
    '{MODE_TICK, 0, 0, 0, 100, 1, 0, ST_SETTLE},
    '{MODE_TICK, 0, 0, 0, 200, 1, 0, ST_SETTLE},
    '{MODE_DET, 10'd1023, 24'd0, 24'd3276, 300, 0, 0, ST_WAIT},
    '{MODE_TICK, 0, 0, 0, 300, 1, 0, ST_WAIT},
    '{MODE_DET, 10'd1023, 24'h800000, 24'h800000, 350, 0, 0, ST_WAIT},
    '{MODE_TICK, 0, 0, 0, 360, 1, 0, ST_WAIT},
    '{MODE_DET, 10'd1023, 24'h7FFFFF, 24'd65536, 400, 0, 0, ST_WAIT},
    '{MODE_TICK, 0, 0, 0, 450, 0, 0, ST_WAIT},
    '{MODE_DET, 10'd1023, 24'h800000, 24'd65536, 500, 0, 0, ST_WAIT},
    '{MODE_TICK, 0, 0, 0, 520, 0, 0, ST_WAIT},
    '{MODE_TICK, 0, 0, 0, 1501, 1, 0, ST_WAIT},
    '{MODE_DET, 10'd1023, 24'd3932, 24'd262144, 5000, 0, 0, ST_WAIT},
    '{MODE_TICK, 0, 0, 0, 2000, 0, 0, ST_WAIT},
    '{MODE_TICK, 0, 0, 0, 2100, 0, 0, ST_WAIT},
    '{MODE_DET, 10'd3, 24'd0, 24'd65536, 2200, 0, 0, ST_WAIT}};

  // Check each output transfer against the oldest expectation
  always @(posedge clk) begin
    aim_result_t e;
    if (out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_tdata);
      end else begin
        e = pending_results.pop_front();
        if (out_tdata[15:0] !== e.rate || out_tdata[18:16] !== e.status ||
            out_tdata[23:19] !== 5'd0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result differs: rate exp %0d got %0d, status exp %0d got %0d",
                     $signed(e.rate), $signed(out_tdata[15:0]), e.status, out_tdata[18:16]);
        end
      end
    end
  end

  // Receiver: random stall before each result, with stretches of none
  initial begin
    int n, cnt;
    cnt = 0;
    @(posedge clk);
    forever begin
      if (++cnt % 60 == 0) calm_recv = ~calm_recv;
      n = calm_recv ? 0 : $urandom_range(0, 19);
      if (n > 0) begin
        out_tready <= 0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Watchdog on cycles with no transfer of any kind
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("target_yaw_aim_controller_unit: mismatch");
      $finish;
    end
  end

  initial begin
    int ending;
    cfg = '{-1, 8192, 1229, 9830, 1311, 524, 3277, 8000};
    aim = '{default: 0};
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (reset_rows[i])
      send(reset_rows[i].mode, reset_rows[i].tag, reset_rows[i].x, reset_rows[i].z,
           reset_rows[i].t, reset_rows[i].typed, reset_rows[i].rate, reset_rows[i].status);
    end_send();
    drain();
    write_reg(CFG_TARGET_TAG, 16'd1023);
    cfg_we <= 0;
    @(posedge clk);
    foreach (aim_rows[i])
      send(aim_rows[i].mode, aim_rows[i].tag, aim_rows[i].x, aim_rows[i].z,
           aim_rows[i].t, aim_rows[i].typed, aim_rows[i].rate, aim_rows[i].status);
    end_send();

    // Random phases: all-max, all-zero, then random settings
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: write_all(16'd1023, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     16'hFFFF);
        1: write_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        5: write_all(16'h0400, 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom_range(0, 3000)), 16'($urandom_range(0, 1000)),
                     16'($urandom_range(0, 8000)), 16'($urandom_range(20000, 65535)));
        default: write_all(16'($urandom_range(0, 1023)), 16'($urandom), 16'($urandom),
                           16'($urandom), 16'($urandom_range(0, 3000)),
                           16'($urandom_range(0, 1000)), 16'($urandom_range(0, 8000)),
                           16'($urandom_range(20000, 65535)));
      endcase
      cur_t = 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 50 == 0) calm_send = ($urandom_range(0, 3) == 0);
        random_item();
      end
      end_send();
    end
    calm_send = 0;

    // Ending: one way of finishing per run, then show that nothing follows
    drain();
    ending = $urandom_range(0, 2);
    if (ending == 0) begin
      write_all(16'd7, 16'd8192, 16'd1229, 16'd9830, 16'd1311, 16'd524, 16'd3277, 16'hFFFF);
      send(MODE_TICK, 0, 0, 0, 32'hFFFF_FFFF, 1, 0, ST_TIMEOUT);
    end else if (ending == 1) begin
      write_all(16'd7, 16'd8192, 16'd1229, 16'd9830, 16'hFFFF, 16'hFFFF, 16'd3277, 16'hFFFF);
      send(MODE_DET, 10'd7, 24'd0, 24'd65536, 1000);
      send(MODE_TICK, 0, 0, 0, 1000);
      send(MODE_DET, 10'd7, 24'd0, 24'd65536, 1500);
      send(MODE_TICK, 0, 0, 0, 1500);
    end else begin
      write_all(16'd7, 16'd8192, 16'd1229, 16'd9830, 16'hFFFF, 16'd0, 16'd3277, 16'hFFFF);
      for (int t = 10000; t <= 13400; t += 400) begin
        send(MODE_DET, 10'd7, 24'd900, 24'd65536, t);
        send(MODE_TICK, 0, 0, 0, t);
      end
    end
    send(MODE_TICK, 0, 0, 0, 100);
    send(MODE_DET, 10'd7, 24'd5, 24'd65536, 100);
    send(MODE_TICK, 0, 0, 0, 120);
    end_send();

    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("target_yaw_aim_controller_unit: match");
    end else begin
      $display("target_yaw_aim_controller_unit: mismatch");
    end
    $finish;
  end

endmodule
